[hdl/rmtbm_pkg.sv]
// ----------------------------------------------------------------------------
// rmtbm_pkg
// Shared types and constants of the region-mapped tagged byte memory.
// ----------------------------------------------------------------------------
`default_nettype none

package rmtbm_pkg;

    // Port widths fixed by the item format
    localparam int ADDR_PORT_BITS = 16;
    localparam int DATA_BITS      = 8;
    localparam int STATUS_BITS    = 3;

    // Configuration port
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 34;
    localparam int REG_COUNT      = 4;

    // Field positions inside one region register
    localparam int FIRST_LSB      = 0;
    localparam int LAST_LSB       = 16;
    localparam int ROM_BIT        = 32;
    localparam int EN_BIT         = 33;

    // Access kind
    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_WRITE   = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_NORMAL     = 3'd0,
        ST_RAM_UNINIT = 3'd1,
        ST_ROM_NOVAL  = 3'd2,
        ST_NO_REGION  = 3'd3,
        ST_STORED_RAM = 3'd4,
        ST_STORED_ROM = 3'd5
    } status_t;

    // Region decode result
    typedef struct packed {
        logic hit;
        logic rom;
    } region_hit_t;

    // Access controls toward the backing store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage

`default_nettype wire

[hdl/rmtbm_regs.sv]
// ----------------------------------------------------------------------------
// rmtbm_regs
// Region registers and the address decoder. The lowest enabled region that
// contains the address decides RAM or ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtbm_regs
    import rmtbm_pkg::*;
#(
    parameter int REGIONS   = 4,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic [ADDR_BITS-1:0]     addr,
    output region_hit_t                   hit
);

    localparam int NumRegs = (REGIONS < REG_COUNT) ? REGIONS : REG_COUNT;

    logic [CFG_DATA_BITS-1:0] region_reg [NumRegs];

    // Register writes; indexes past the implemented set are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumRegs; i++) begin
                region_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < NumRegs; i++) begin
                if (cfg_index == CFG_IDX_BITS'(i)) begin
                    region_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Priority decode: scan from the top so the lowest index wins
    always_comb begin
        logic [ADDR_BITS-1:0] first_a;
        logic [ADDR_BITS-1:0] last_a;
        hit = '0;
        for (int i = NumRegs - 1; i >= 0; i--) begin
            first_a = region_reg[i][FIRST_LSB +: ADDR_BITS];
            last_a  = region_reg[i][LAST_LSB +: ADDR_BITS];
            if (region_reg[i][EN_BIT] && (addr >= first_a) && (addr <= last_a)) begin
                hit.hit = 1'b1;
                hit.rom = region_reg[i][ROM_BIT];
            end
        end
    end

endmodule

`default_nettype wire

[hdl/rmtbm_store.sv]
// ----------------------------------------------------------------------------
// rmtbm_store
// Backing byte RAM and written-mark RAM, both with registered synchronous reads.
// The mark RAM is swept to zero after reset, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtbm_store
    import rmtbm_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  mem_ctrl_t                 ctrl,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0]      rd_byte,
    output logic                      rd_mark,
    output logic                      clearing
);

    localparam int Depth = 2 ** ADDR_BITS;

    logic [DATA_BITS-1:0] byte_mem [Depth];
    logic                 mark_mem [Depth];

    logic                 clear_reg;
    logic                 clear_next;
    logic [ADDR_BITS-1:0] clear_addr_reg;
    logic [ADDR_BITS-1:0] clear_addr_next;
    logic [DATA_BITS-1:0] byte_rd_reg;
    logic                 mark_rd_reg;

    logic                 mark_we;
    logic [ADDR_BITS-1:0] mark_waddr;
    logic                 mark_wdata;

    // Clear sweep control
    always_comb begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg) begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (&clear_addr_reg) begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end else begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // Mark port: sweep has the port while clearing, accesses otherwise
    assign mark_we    = clear_reg || ctrl.wr_en;
    assign mark_waddr = clear_reg ? clear_addr_reg : addr;
    assign mark_wdata = !clear_reg;

    // Byte RAM
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            byte_mem[addr] <= wdata;
        end
        if (ctrl.rd_en) begin
            byte_rd_reg <= byte_mem[addr];
        end
    end

    // Written-mark RAM
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (ctrl.rd_en) begin
            mark_rd_reg <= mark_mem[addr];
        end
    end

    assign rd_byte  = byte_rd_reg;
    assign rd_mark  = mark_rd_reg;
    assign clearing = clear_reg;

endmodule

`default_nettype wire

[hdl/region_mapped_tagged_byte_memory.sv]
// Path: an accepted transfer is registered in stage 1, then in the output register.
// Throughput: one access per cycle unless the mark sweep or a stalled output
// drops s_ready; writes reach the RAMs at the accept edge, seen by the next read.
// Reset: region registers clear to disabled; the written-mark RAM is then
// swept over all 2**ADDR_BITS entries (65536 at default), with s_ready low meanwhile.
// ----------------------------------------------------------------------------
// region_mapped_tagged_byte_memory
// Address-range decoder with up to four RAM/ROM windows in front of a byte
// store that tracks which bytes have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module region_mapped_tagged_byte_memory
    import rmtbm_pkg::*;
#(
    parameter int REGIONS   = 4,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Access request
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [ADDR_PORT_BITS-1:0] s_address,
    input  wire logic [DATA_BITS-1:0]      s_write_data,
    // Result
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [DATA_BITS-1:0]           m_read_data,
    output logic [STATUS_BITS-1:0]         m_status,
    // Configuration writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [ADDR_BITS-1:0] addr;
    region_hit_t          hit;
    mem_ctrl_t            mem_ctrl;
    logic [DATA_BITS-1:0] rd_byte;
    logic                 rd_mark;
    logic                 clearing;
    logic                 accept;
    logic                 s1_advance;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_kind_reg;
    region_hit_t          s1_hit_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DATA_BITS-1:0] out_data_reg;
    logic [DATA_BITS-1:0] out_data_next;
    status_t              out_status_reg;
    status_t              out_status_next;

    assign addr      = s_address[ADDR_BITS-1:0];
    assign cfg_ready = 1'b1;

    rmtbm_regs #(
        .REGIONS   (REGIONS),
        .ADDR_BITS (ADDR_BITS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addr      (addr),
        .hit       (hit)
    );

    // Handshake: stage 1 moves on when the output register is empty or being taken
    assign s1_advance = !out_valid_reg || m_ready;
    assign s_ready    = !clearing && (!s1_valid_reg || s1_advance);
    assign accept     = s_valid && s_ready;

    // Store access issued at accept; writes only land inside a region
    assign mem_ctrl.rd_en = accept;
    assign mem_ctrl.wr_en = accept && (s_kind == KIND_WRITE) && hit.hit;

    rmtbm_store #(
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mem_ctrl),
        .addr     (addr),
        .wdata    (s_write_data),
        .rd_byte  (rd_byte),
        .rd_mark  (rd_mark),
        .clearing (clearing)
    );

    // Stage 1 valid and output valid
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_advance) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg <= s_kind;
            s1_hit_reg  <= hit;
        end
    end

    // Result status from decode and written mark
    always_comb begin
        out_data_next = '0;
        if (!s1_hit_reg.hit) begin
            out_status_next = ST_NO_REGION;
        end else if (s1_kind_reg == KIND_WRITE) begin
            out_status_next = s1_hit_reg.rom ? ST_STORED_ROM : ST_STORED_RAM;
        end else if (rd_mark) begin
            out_status_next = ST_NORMAL;
            out_data_next   = rd_byte;
        end else begin
            out_status_next = s1_hit_reg.rom ? ST_ROM_NOVAL : ST_RAM_UNINIT;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_data_reg;
    assign m_status    = out_status_reg;

endmodule

`default_nettype wire

[hdl/rmtbm_checker.sv]
// ----------------------------------------------------------------------------
// rmtbm_checker
// Port-level checks on the region-mapped tagged byte memory, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtbm_checker
    import rmtbm_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [DATA_BITS-1:0]      m_read_data,
    input wire logic [STATUS_BITS-1:0]    m_status
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_status))
        else $error("result changed while stalled");

    // Only defined status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_STORED_ROM))
        else $error("undefined status code");

    // Data is zero unless a normal read
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_NORMAL) |-> m_read_data == '0)
        else $error("nonzero data on non-normal result");

    // Mark sweep blocks requests right after reset
    a_sweep_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request accepted during mark sweep");

    // A fresh result traces back to a transfer accepted into stage 1 just before
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching request");

endmodule

bind region_mapped_tagged_byte_memory rmtbm_checker u_rmtbm_checker (.*);

`default_nettype wire
